@@ rtl/ttt_pkg.sv @@
// Shared types and constants for the template tag tokenizer.
// No dependencies; used by ttt_scan, ttt_res_fifo and template_tag_tokenizer.
`default_nettype none

package ttt_pkg;

  // Default width of the internal byte position counter.
  localparam int unsigned PosBitsDef = 16;
  // Width of every reported offset.
  localparam int unsigned OffW       = 16;
  // Result buffer depth; one step writes at most two records.
  localparam int unsigned ResDepth   = 4;
  localparam int unsigned ResPtrW    = $clog2(ResDepth);
  localparam int unsigned ResCntW    = $clog2(ResDepth + 1);

  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChPct    = 8'h25;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;

  typedef enum logic [1:0] {
    MODE_OUT     = 2'd0,
    MODE_NAME    = 2'd1,
    MODE_BODY    = 2'd2,
    MODE_COMMENT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_TAG  = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_source;
  } in_beat_t;

  typedef struct packed {
    kind_e             kind;
    logic [OffW-1:0]   span_start;
    logic [OffW-1:0]   span_end;
    logic [OffW-1:0]   name_start;
    logic [OffW-1:0]   name_end;
    logic [OffW-1:0]   text_number;
    logic              unterminated;
    logic              overflow;
    logic              last;
  } res_beat_t;

  // Records produced by one scan step, in order, and how many are valid.
  typedef struct packed {
    res_beat_t   rec0;
    res_beat_t   rec1;
    logic [1:0]  num;
  } scan_out_t;

endpackage

`default_nettype wire

@@ rtl/ttt_scan.sv @@
// Scan step of the template tag tokenizer: holds the scanner state and
// turns one source byte into up to two records. Depends on ttt_pkg.
`default_nettype none

module ttt_scan #(
  parameter int unsigned POS_BITS = ttt_pkg::PosBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire ttt_pkg::in_beat_t   beat_i,
  output ttt_pkg::scan_out_t       out_o
);

  localparam logic [POS_BITS-1:0] PosMax = '1;
  localparam logic [POS_BITS-1:0] PosOne = POS_BITS'(1);
  localparam logic [POS_BITS-1:0] PosZero = '0;

  ttt_pkg::mode_e        mode_q, mode_d;
  logic [7:0]            held_byte_q, held_byte_d;
  logic                  held_valid_q, held_valid_d;
  logic [POS_BITS-1:0]   pos_q, pos_d;
  logic [POS_BITS-1:0]   seg_q, seg_d;
  logic [POS_BITS-1:0]   name_start_q, name_start_d;
  logic [POS_BITS-1:0]   name_end_q, name_end_d;
  logic [15:0]           text_cnt_q, text_cnt_d;
  logic                  ovf_q, ovf_d;

  // Step decode
  logic [7:0]            b;
  logic                  eos;
  logic [POS_BITS-1:0]   p, nxt, prv;
  logic                  ovf_now;
  logic                  open_hit, close_tag, close_cmt, consumed;
  logic                  blank_hit, hold_hit;
  ttt_pkg::mode_e        mode_mid;
  logic [POS_BITS-1:0]   seg_mid;
  logic                  text_a, text_b;

  always_comb begin
    b        = beat_i.data_byte;
    eos      = beat_i.end_of_source;
    p        = pos_q;
    ovf_now  = ovf_q | (pos_q == PosMax);
    nxt      = (p == PosMax) ? PosMax : p + PosOne;
    prv      = (p == PosZero) ? PosZero : p - PosOne;

    open_hit  = held_valid_q && (mode_q == ttt_pkg::MODE_OUT) &&
                (held_byte_q == ttt_pkg::ChLBrace) &&
                ((b == ttt_pkg::ChPct) || (b == ttt_pkg::ChStar));
    close_tag = held_valid_q &&
                ((mode_q == ttt_pkg::MODE_NAME) || (mode_q == ttt_pkg::MODE_BODY)) &&
                (held_byte_q == ttt_pkg::ChPct) && (b == ttt_pkg::ChRBrace);
    close_cmt = held_valid_q && (mode_q == ttt_pkg::MODE_COMMENT) &&
                (held_byte_q == ttt_pkg::ChStar) && (b == ttt_pkg::ChRBrace);
    consumed  = open_hit | close_tag | close_cmt;

    blank_hit = !consumed && (mode_q == ttt_pkg::MODE_NAME) &&
                ((b == ttt_pkg::ChSpace) || (b == ttt_pkg::ChTab));
    hold_hit  = !consumed && !blank_hit &&
                (((mode_q == ttt_pkg::MODE_OUT) && (b == ttt_pkg::ChLBrace)) ||
                 (((mode_q == ttt_pkg::MODE_NAME) || (mode_q == ttt_pkg::MODE_BODY)) &&
                  (b == ttt_pkg::ChPct)) ||
                 ((mode_q == ttt_pkg::MODE_COMMENT) && (b == ttt_pkg::ChStar)));

    mode_mid = mode_q;
    seg_mid  = seg_q;
    if (open_hit) begin
      mode_mid = (b == ttt_pkg::ChPct) ? ttt_pkg::MODE_NAME : ttt_pkg::MODE_COMMENT;
      seg_mid  = nxt;
    end else if (close_tag || close_cmt) begin
      mode_mid = ttt_pkg::MODE_OUT;
      seg_mid  = nxt;
    end else if (blank_hit) begin
      mode_mid = ttt_pkg::MODE_BODY;
      seg_mid  = p;
    end

    // Text before an opener, and trailing text at the end of the source
    text_a = open_hit && (prv > seg_q);
    text_b = eos && (mode_mid == ttt_pkg::MODE_OUT) && (nxt > seg_mid);
  end

  // Next state
  always_comb begin
    mode_d        = mode_mid;
    seg_d         = seg_mid;
    pos_d         = nxt;
    ovf_d         = ovf_now;
    held_valid_d  = hold_hit;
    held_byte_d   = hold_hit ? b : held_byte_q;
    name_start_d  = blank_hit ? seg_q : name_start_q;
    name_end_d    = blank_hit ? p : name_end_q;
    text_cnt_d    = text_cnt_q + 16'(text_a | text_b);
    if (eos) begin
      // Back to the reset state for the next source
      mode_d       = ttt_pkg::MODE_OUT;
      seg_d        = '0;
      pos_d        = '0;
      ovf_d        = 1'b0;
      held_valid_d = 1'b0;
      held_byte_d  = '0;
      name_start_d = '0;
      name_end_d   = '0;
      text_cnt_d   = '0;
    end
  end

  // Records
  ttt_pkg::res_beat_t prim, fin;
  logic               has_prim;

  always_comb begin
    prim      = '0;
    fin       = '0;
    has_prim  = text_a | close_tag | text_b;

    if (text_a) begin
      prim.kind        = ttt_pkg::KIND_TEXT;
      prim.span_start  = 16'(seg_q);
      prim.span_end    = 16'(prv);
      prim.text_number = text_cnt_q;
    end else if (close_tag) begin
      prim.kind     = ttt_pkg::KIND_TAG;
      prim.span_end = 16'(prv);
      if (mode_q == ttt_pkg::MODE_NAME) begin
        // Name-only form: empty body at the closer
        prim.span_start = 16'(prv);
        prim.name_start = 16'(seg_q);
        prim.name_end   = 16'(prv);
      end else begin
        prim.span_start = 16'(seg_q);
        prim.name_start = 16'(name_start_q);
        prim.name_end   = 16'(name_end_q);
      end
    end else if (text_b) begin
      prim.kind        = ttt_pkg::KIND_TEXT;
      prim.span_start  = 16'(seg_mid);
      prim.span_end    = 16'(nxt);
      prim.text_number = text_cnt_q;
    end

    fin.kind         = ttt_pkg::KIND_END;
    fin.span_end     = 16'(nxt);
    fin.unterminated = (mode_mid != ttt_pkg::MODE_OUT);
    fin.overflow     = ovf_now;
    fin.last         = 1'b1;

    out_o.num = {1'b0, has_prim} + {1'b0, eos};
    if (has_prim) begin
      out_o.rec0      = prim;
      out_o.rec0.last = !eos;
      out_o.rec1      = fin;
    end else begin
      out_o.rec0 = fin;
      out_o.rec1 = fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ttt_pkg::MODE_OUT;
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      pos_q        <= '0;
      seg_q        <= '0;
      name_start_q <= '0;
      name_end_q   <= '0;
      text_cnt_q   <= '0;
      ovf_q        <= 1'b0;
    end else if (step_i) begin
      mode_q       <= mode_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      pos_q        <= pos_d;
      seg_q        <= seg_d;
      name_start_q <= name_start_d;
      name_end_q   <= name_end_d;
      text_cnt_q   <= text_cnt_d;
      ovf_q        <= ovf_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ttt_res_fifo.sv @@
// Small result buffer: takes up to two records per cycle, hands out one unless stalled.
// Depends on ttt_pkg.
`default_nettype none

module ttt_res_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire ttt_pkg::scan_out_t  recs_i,
  output logic                     room2_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ttt_pkg::res_beat_t       out_data_o
);

  ttt_pkg::res_beat_t                mem_q [ttt_pkg::ResDepth];
  logic [ttt_pkg::ResPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [ttt_pkg::ResPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [ttt_pkg::ResCntW-1:0]       cnt_q, cnt_d;
  logic [1:0]                        n_push;
  logic                              pop;
  logic [ttt_pkg::ResPtrW-1:0]       wr_ptr_1;

  always_comb begin
    n_push      = push_i ? recs_i.num : 2'd0;
    out_valid_o = (cnt_q != '0);
    pop         = out_valid_o && !out_stall_i;
    out_data_o  = mem_q[rd_ptr_q];
    room2_o     = (cnt_q <= ttt_pkg::ResCntW'(ttt_pkg::ResDepth - 2));
    wr_ptr_1    = wr_ptr_q + ttt_pkg::ResPtrW'(1);
    wr_ptr_d    = wr_ptr_q + ttt_pkg::ResPtrW'(n_push);
    rd_ptr_d    = rd_ptr_q + ttt_pkg::ResPtrW'(pop);
    cnt_d       = cnt_q + ttt_pkg::ResCntW'(n_push) - ttt_pkg::ResCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= recs_i.rec0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_ptr_1] <= recs_i.rec1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/template_tag_tokenizer.sv @@
// Template tag tokenizer top level: input register, scan step, result buffer.
// Depends on ttt_pkg, ttt_scan and ttt_res_fifo.
//
// Usage: source bytes arrive on the input channel (in_valid_i / in_stall_o,
// payload in_data_i), one byte per beat, the final byte of a source marked by
// end_of_source. Records leave on the output channel (out_valid_o /
// out_stall_i, payload out_data_o): text spans, tags and one end record per
// source; the last field marks the final record caused by a byte.
// The input register holds an accepted byte; the scan step reads it from
// there and writes its records into the result buffer, which offers them.
// Throughput: one byte per cycle while bytes cause at most one record each
// and the receiver does not stall; a byte that causes two records (text or
// tag followed by the end record) is taken up by a four-record result buffer.
// The scan step runs when the buffer has room for two records.
// Reset clears the scanner to "outside any tag", position zero, and empties
// the input register and the buffer. A stalled receiver fills the buffer;
// the input register then holds its byte and in_stall_o rises.
`default_nettype none

module template_tag_tokenizer #(
  parameter int unsigned POS_BITS = ttt_pkg::PosBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ttt_pkg::in_beat_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ttt_pkg::res_beat_t       out_data_o
);

  logic                 in_vld_q, in_vld_d;
  ttt_pkg::in_beat_t    in_beat_q;
  logic                 room2;
  logic                 step;
  logic                 load;
  ttt_pkg::scan_out_t   recs;

  always_comb begin
    step       = in_vld_q && room2;
    in_stall_o = in_vld_q && !room2;
    load       = in_valid_i && !in_stall_o;
    in_vld_d   = load | (in_vld_q & !step);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_beat_q <= in_data_i;
    end
  end

  ttt_scan #(
    .POS_BITS (POS_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .beat_i (in_beat_q),
    .out_o  (recs)
  );

  ttt_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .recs_i      (recs),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
